// ===== rtl/rpc_pkg.sv =====
// rpc_pkg: shared types, status codes and helpers for the ntp reply checker
// used by every module under rtl; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

	localparam int unsigned CountW = 6;
	localparam int unsigned MsW    = 42;

	// status codes of a result transaction
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_MISMATCH  = 3'd2;
	localparam logic [2:0] ST_KISS      = 3'd3;
	localparam logic [2:0] ST_UNSYNCED  = 3'd4;

	// byte positions inside the reply
	localparam logic [CountW-1:0] POS_HEADER   = 6'd0;
	localparam logic [CountW-1:0] POS_STRATUM  = 6'd1;
	localparam logic [CountW-1:0] POS_REF_LO   = 6'd12;
	localparam logic [CountW-1:0] POS_ORIG_LO  = 6'd24;
	localparam logic [CountW-1:0] POS_RECV_LO  = 6'd32;
	localparam logic [CountW-1:0] POS_XMIT_LO  = 6'd40;
	localparam logic [CountW-1:0] POS_END      = 6'd48;
	localparam logic [CountW-1:0] POS_LAST     = 6'd47;
	localparam logic [CountW-1:0] COUNT_MAX    = 6'd63;

	localparam logic [2:0] MODE_SERVER    = 3'd4;
	localparam logic [2:0] VERSION_LO     = 3'd3;
	localparam logic [2:0] VERSION_HI     = 3'd4;
	localparam logic [1:0] LEAP_ALARM     = 2'd3;
	localparam logic [7:0] STRATUM_UNSYNC = 8'd16;

	// stamp order inside the ms arrays
	localparam int unsigned T_SENT = 0;
	localparam int unsigned T_RECV = 1;
	localparam int unsigned T_XMIT = 2;
	localparam int unsigned T_ARRV = 3;

	typedef struct packed {
		logic [7:0]  msg_byte;
		logic        last_byte;
		logic [63:0] sent_time;
		logic [63:0] arrived_time;
	} rpc_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [43:0] clk_offset;
		logic [42:0]        rtt_delay;
		logic [7:0]         stratum;
		logic [31:0]        ref_id;
	} rpc_out_t;

	// everything gathered from one reply
	typedef struct packed {
		logic        len_ok;
		logic [7:0]  header;
		logic [7:0]  stratum;
		logic [31:0] ref_word;
		logic [63:0] origin;
		logic [63:0] receive;
		logic [63:0] transmit;
		logic [63:0] sent;
		logic [63:0] arrival;
	} rpc_snap_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  stratum;
		logic [31:0] ref_id;
	} rpc_meta_t;

	typedef struct packed {
		logic [MsW-1:0] sec_ms;
		logic [9:0]     frac_ms;
	} rpc_ms_part_t;

	// x * 1000 as shifts and subtracts, x below 2^32
	function automatic logic [MsW-1:0] mul1000(input logic [31:0] x);
		logic [MsW-1:0] w;
		w = {10'd0, x};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rpc_collect.sv =====
// rpc_collect: byte counter and field capture for one reply, snapshot on last byte
// depends on rpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpc_collect (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               msg_valid,
	output logic                    msg_stall,
	input  wire rpc_pkg::rpc_in_t   msg,
	output logic                    snap_valid,
	input  wire logic               snap_stall,
	output rpc_pkg::rpc_snap_t      snap
);
	import rpc_pkg::*;

	logic [CountW-1:0] count_q;
	logic [7:0]        header_q;
	logic [7:0]        stratum_q;
	logic [31:0]       ref_q;
	logic [63:0]       origin_q;
	logic [63:0]       receive_q;
	logic [63:0]       transmit_q;
	logic [63:0]       sent_q;
	logic [63:0]       arrival_q;

	logic              snap_valid_s1;
	rpc_snap_t         snap_s1;
	rpc_snap_t         next_d;
	logic              accept;
	logic [CountW-1:0] pos;

	assign msg_stall  = snap_valid_s1 && snap_stall;
	assign accept     = msg_valid && !msg_stall;
	assign pos        = count_q;
	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

	always_comb begin
		next_d.len_ok   = (pos == POS_LAST);
		next_d.header   = header_q;
		next_d.stratum  = stratum_q;
		next_d.ref_word = ref_q;
		next_d.origin   = origin_q;
		next_d.receive  = receive_q;
		next_d.transmit = transmit_q;
		next_d.sent     = sent_q;
		next_d.arrival  = arrival_q;
		if (pos == POS_HEADER) begin
			next_d.header  = msg.msg_byte;
			next_d.sent    = msg.sent_time;
			next_d.arrival = msg.arrived_time;
		end else if (pos == POS_STRATUM) begin
			next_d.stratum = msg.msg_byte;
		end else if (pos >= POS_REF_LO && pos < POS_REF_LO + 6'd4) begin
			next_d.ref_word = {ref_q[23:0], msg.msg_byte};
		end else if (pos >= POS_ORIG_LO && pos < POS_RECV_LO) begin
			next_d.origin = {origin_q[55:0], msg.msg_byte};
		end else if (pos >= POS_RECV_LO && pos < POS_XMIT_LO) begin
			next_d.receive = {receive_q[55:0], msg.msg_byte};
		end else if (pos >= POS_XMIT_LO && pos < POS_END) begin
			next_d.transmit = {transmit_q[55:0], msg.msg_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (msg.last_byte) begin
					count_q <= '0;
				end else if (count_q != COUNT_MAX) begin
					count_q <= count_q + 6'd1;
				end
			end
			if (!msg_stall) begin
				snap_valid_s1 <= accept && msg.last_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			header_q   <= next_d.header;
			stratum_q  <= next_d.stratum;
			ref_q      <= next_d.ref_word;
			origin_q   <= next_d.origin;
			receive_q  <= next_d.receive;
			transmit_q <= next_d.transmit;
			sent_q     <= next_d.sent;
			arrival_q  <= next_d.arrival;
			if (msg.last_byte) begin
				snap_s1 <= next_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rpc_check.sv =====
// rpc_check: header checks in order and the split ms conversion of the four stamps
// depends on rpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpc_check (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      snap_valid,
	output logic                           snap_stall,
	input  wire rpc_pkg::rpc_snap_t        snap,
	output logic                           part_valid,
	input  wire logic                      part_stall,
	output rpc_pkg::rpc_meta_t             part_meta,
	output rpc_pkg::rpc_ms_part_t [3:0]    part
);
	import rpc_pkg::*;

	logic                  valid_s2;
	rpc_meta_t             meta_s2;
	rpc_ms_part_t [3:0]    part_s2;
	rpc_meta_t             meta_d;
	rpc_ms_part_t [3:0]    part_d;
	logic [63:0]           stamp [4];
	logic [MsW-1:0]        frac_prod [4];
	logic [1:0]            leap;
	logic [2:0]            version;
	logic [2:0]            mode;
	logic                  hdr_ok;

	assign snap_stall = valid_s2 && part_stall;
	assign part_valid = valid_s2;
	assign part_meta  = meta_s2;
	assign part       = part_s2;

	assign leap    = snap.header[7:6];
	assign version = snap.header[5:3];
	assign mode    = snap.header[2:0];
	assign hdr_ok  = snap.len_ok && (mode == MODE_SERVER) &&
		(version == VERSION_LO || version == VERSION_HI);

	always_comb begin
		if (!snap.len_ok) begin
			meta_d.status = ST_MALFORMED;
		end else if (mode != MODE_SERVER) begin
			meta_d.status = ST_MISMATCH;
		end else if (version != VERSION_LO && version != VERSION_HI) begin
			meta_d.status = ST_MALFORMED;
		end else if (snap.stratum == 8'd0) begin
			meta_d.status = ST_KISS;
		end else if (snap.stratum >= STRATUM_UNSYNC || leap == LEAP_ALARM) begin
			meta_d.status = ST_UNSYNCED;
		end else if (snap.origin != snap.sent) begin
			meta_d.status = ST_MISMATCH;
		end else if (snap.transmit == 64'd0) begin
			meta_d.status = ST_MALFORMED;
		end else begin
			meta_d.status = ST_OK;
		end
		meta_d.stratum = hdr_ok ? snap.stratum : 8'd0;
		meta_d.ref_id  = hdr_ok ? snap.ref_word : 32'd0;
	end

	assign stamp[T_SENT] = snap.sent;
	assign stamp[T_RECV] = snap.receive;
	assign stamp[T_XMIT] = snap.transmit;
	assign stamp[T_ARRV] = snap.arrival;

	// seconds part and fraction part of each stamp, summed later in rpc_arith
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			frac_prod[i]      = mul1000(stamp[i][31:0]);
			part_d[i].sec_ms  = mul1000(stamp[i][63:32]);
			part_d[i].frac_ms = frac_prod[i][MsW-1:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!snap_stall) begin
			valid_s2 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!snap_stall && snap_valid) begin
			meta_s2 <= meta_d;
			part_s2 <= part_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rpc_arith.sv =====
// rpc_arith: stamp totals in ms, pairwise differences, then offset and delay sums
// depends on rpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpc_arith (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      part_valid,
	output logic                           part_stall,
	input  wire rpc_pkg::rpc_meta_t        part_meta,
	input  wire rpc_pkg::rpc_ms_part_t [3:0] part,
	output logic                           sum_valid,
	input  wire logic                      sum_stall,
	output rpc_pkg::rpc_meta_t             sum_meta,
	output logic signed [43:0]             off_sum,
	output logic signed [43:0]             del_sum
);
	import rpc_pkg::*;

	logic                  valid_s3;
	logic                  valid_s4;
	logic                  valid_s5;
	logic                  stall_s3;
	logic                  stall_s4;
	logic                  stall_s5;
	rpc_meta_t             meta_s3;
	rpc_meta_t             meta_s4;
	rpc_meta_t             meta_s5;
	logic [MsW-1:0]        t_s3 [4];
	logic signed [MsW:0]   d21_s4;
	logic signed [MsW:0]   d34_s4;
	logic signed [MsW:0]   d41_s4;
	logic signed [MsW:0]   d32_s4;
	logic signed [43:0]    off_s5;
	logic signed [43:0]    del_s5;

	assign stall_s5   = valid_s5 && sum_stall;
	assign stall_s4   = valid_s4 && stall_s5;
	assign stall_s3   = valid_s3 && stall_s4;
	assign part_stall = stall_s3;

	assign sum_valid = valid_s5;
	assign sum_meta  = meta_s5;
	assign off_sum   = off_s5;
	assign del_sum   = del_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (!stall_s3) begin
				valid_s3 <= part_valid;
			end
			if (!stall_s4) begin
				valid_s4 <= valid_s3;
			end
			if (!stall_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s3 && part_valid) begin
			meta_s3 <= part_meta;
			for (int i = 0; i < 4; i++) begin
				t_s3[i] <= part[i].sec_ms + {{(MsW-10){1'b0}}, part[i].frac_ms};
			end
		end
		if (!stall_s4 && valid_s3) begin
			meta_s4 <= meta_s3;
			d21_s4  <= $signed({1'b0, t_s3[T_RECV]}) - $signed({1'b0, t_s3[T_SENT]});
			d34_s4  <= $signed({1'b0, t_s3[T_XMIT]}) - $signed({1'b0, t_s3[T_ARRV]});
			d41_s4  <= $signed({1'b0, t_s3[T_ARRV]}) - $signed({1'b0, t_s3[T_SENT]});
			d32_s4  <= $signed({1'b0, t_s3[T_XMIT]}) - $signed({1'b0, t_s3[T_RECV]});
		end
		if (!stall_s5 && valid_s4) begin
			meta_s5 <= meta_s4;
			off_s5  <= {d21_s4[MsW], d21_s4} + {d34_s4[MsW], d34_s4};
			del_s5  <= {d41_s4[MsW], d41_s4} - {d32_s4[MsW], d32_s4};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ntp_reply_check_offset_delay_core.sv =====
// ntp_reply_check_offset_delay_core: top level, byte capture, checks, arithmetic
// and the result register; depends on rpc_pkg, rpc_collect, rpc_check, rpc_arith
`timescale 1ns / 1ps
`default_nettype none

// Takes one reply byte per cycle on msg while msg is not stalled; the local sent
// and arrival stamps are sampled with the first byte of each reply. The byte
// marked last yields one result transaction on res through the registers of the
// snapshot, the checks with the seconds/fraction split of the ms conversion, the
// ms totals, the pairwise differences, the offset and delay sums, and the result
// register. Bytes of the next reply are taken in the cycle after a last byte
// unless msg stalls; msg stalls only when every stage up to the snapshot is full
// behind a stalled res. clk_offset and rtt_delay are zero unless status is ok;
// stratum and ref_id are zero when length, mode or version fail.
module ntp_reply_check_offset_delay_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             msg_valid,
	output logic                  msg_stall,
	input  wire rpc_pkg::rpc_in_t msg,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output rpc_pkg::rpc_out_t     res
);
	import rpc_pkg::*;

	logic                  snap_valid;
	logic                  snap_stall;
	rpc_snap_t             snap;
	logic                  part_valid;
	logic                  part_stall;
	rpc_meta_t             part_meta;
	rpc_ms_part_t [3:0]    part;
	logic                  sum_valid;
	logic                  sum_stall;
	rpc_meta_t             sum_meta;
	logic signed [43:0]    off_sum;
	logic signed [43:0]    del_sum;

	logic                  res_valid_q;
	rpc_out_t              res_q;
	rpc_out_t              res_d;
	logic signed [43:0]    off_adj;
	logic signed [43:0]    off_half;
	logic                  is_ok;

	rpc_collect u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg        (msg),
		.snap_valid (snap_valid),
		.snap_stall (snap_stall),
		.snap       (snap)
	);

	rpc_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_stall (snap_stall),
		.snap       (snap),
		.part_valid (part_valid),
		.part_stall (part_stall),
		.part_meta  (part_meta),
		.part       (part)
	);

	rpc_arith u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.part_valid (part_valid),
		.part_stall (part_stall),
		.part_meta  (part_meta),
		.part       (part),
		.sum_valid  (sum_valid),
		.sum_stall  (sum_stall),
		.sum_meta   (sum_meta),
		.off_sum    (off_sum),
		.del_sum    (del_sum)
	);

	assign sum_stall = res_valid_q && res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// halve toward zero: bump negative sums by one before the shift
	assign off_adj  = off_sum + $signed({43'd0, off_sum[43]});
	assign off_half = off_adj >>> 1;
	assign is_ok    = (sum_meta.status == ST_OK);

	always_comb begin
		res_d.status     = sum_meta.status;
		res_d.stratum    = sum_meta.stratum;
		res_d.ref_id     = sum_meta.ref_id;
		res_d.clk_offset = is_ok ? off_half : 44'sd0;
		// a non-negative 44-bit sum never exceeds the 43-bit ceiling
		res_d.rtt_delay  = (is_ok && !del_sum[43]) ? del_sum[42:0] : 43'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!sum_stall) begin
			res_valid_q <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sum_stall && sum_valid) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_ntp_reply_check_offset_delay_core.sv =====
`timescale 1ns / 1ps
// tb_ntp_reply_check_offset_delay_core: self-checking testbench for the ntp reply checker
// streams reply bytes with random idling and back-pressure and predicts every result itself
// depends on rpc_pkg and ntp_reply_check_offset_delay_core

module tb_ntp_reply_check_offset_delay_core;
	import rpc_pkg::*;

	localparam int          IdleLimit  = 2000;
	localparam int          RandBytes  = 150;
	localparam int          MinReplies = 3;
	localparam int          DrainWait  = 16;
	localparam longint      DelayCap   = 64'sh0000_07FF_FFFF_FFFF;
	localparam logic [2:0]  MODE_CLIENT  = 3'd3;
	localparam logic [2:0]  MODE_BCAST   = 3'd5;
	localparam logic [2:0]  VERSION_OLD  = 3'd2;
	localparam logic [2:0]  VERSION_NEXT = 3'd5;
	localparam logic [1:0]  LEAP_NONE    = 2'd0;
	localparam logic [1:0]  LEAP_ADD     = 2'd1;
	localparam logic [63:0] StampSent = 64'hE8A1_2345_8000_0000;
	localparam logic [63:0] StampRecv = 64'hE8A1_2345_9000_0000;
	localparam logic [63:0] StampXmit = 64'hE8A1_2345_9100_0000;
	localparam logic [63:0] StampArrv = 64'hE8A1_2345_B000_0000;
	localparam logic [63:0] StampOnes = 64'hFFFF_FFFF_FFFF_FFFF;

	logic     clk;
	logic     arst_n;
	logic     msg_valid;
	logic     msg_stall;
	rpc_in_t  msg;
	logic     res_valid;
	logic     res_stall;
	rpc_out_t res;

	// reply state as the block should hold it
	logic [5:0]  reply_pos;
	logic [7:0]  hdr_seen;
	logic [7:0]  strat_seen;
	logic [31:0] refid_seen;
	logic [63:0] orig_seen;
	logic [63:0] recv_seen;
	logic [63:0] xmit_seen;
	logic [63:0] sent_seen;
	logic [63:0] arrv_seen;

	rpc_out_t    expected_reports[$];
	logic [7:0]  frame[$];

	int errors;
	int bytes_sent;
	int replies_sent;
	int results_checked;
	int status_hits[5];
	bit idle_en;
	int hold_cycles;

	ntp_reply_check_offset_delay_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	function automatic longint stamp_ms(input logic [63:0] ts);
		logic [63:0] whole;
		logic [63:0] part;
		whole = {32'd0, ts[63:32]} * 64'd1000;
		part  = ({32'd0, ts[31:0]} * 64'd1000) >> 32;
		return longint'(whole + part);
	endfunction

	// advance the reply state by one accepted byte, queue a result on a last byte
	task automatic track_reply_byte(input rpc_in_t item);
		int         len;
		rpc_out_t   r;
		logic [1:0] leap;
		logic [2:0] ver;
		logic [2:0] mode;
		longint     t1, t2, t3, t4, off_ms, del_ms;
		if (reply_pos == POS_HEADER) begin
			sent_seen = item.sent_time;
			arrv_seen = item.arrived_time;
			hdr_seen  = item.msg_byte;
		end else if (reply_pos == POS_STRATUM) begin
			strat_seen = item.msg_byte;
		end else if (reply_pos >= POS_REF_LO && reply_pos < POS_REF_LO + 4) begin
			refid_seen = {refid_seen[23:0], item.msg_byte};
		end else if (reply_pos >= POS_ORIG_LO && reply_pos < POS_RECV_LO) begin
			orig_seen = {orig_seen[55:0], item.msg_byte};
		end else if (reply_pos >= POS_RECV_LO && reply_pos < POS_XMIT_LO) begin
			recv_seen = {recv_seen[55:0], item.msg_byte};
		end else if (reply_pos >= POS_XMIT_LO && reply_pos < POS_END) begin
			xmit_seen = {xmit_seen[55:0], item.msg_byte};
		end
		len = int'(reply_pos) + 1;
		if (len > COUNT_MAX)
			len = COUNT_MAX;
		if (!item.last_byte) begin
			reply_pos = 6'(len);
			return;
		end
		reply_pos = '0;
		r = '0;
		r.status = ST_OK;
		leap = hdr_seen[7:6];
		ver  = hdr_seen[5:3];
		mode = hdr_seen[2:0];
		if (len != POS_END) begin
			r.status = ST_MALFORMED;
		end else if (mode != MODE_SERVER) begin
			r.status = ST_MISMATCH;
		end else if (ver < VERSION_LO || ver > VERSION_HI) begin
			r.status = ST_MALFORMED;
		end else begin
			r.stratum = strat_seen;
			r.ref_id  = refid_seen;
			if (strat_seen == 0) begin
				r.status = ST_KISS;
			end else if (strat_seen >= STRATUM_UNSYNC || leap == LEAP_ALARM) begin
				r.status = ST_UNSYNCED;
			end else if (orig_seen != sent_seen) begin
				r.status = ST_MISMATCH;
			end else if (xmit_seen == 0) begin
				r.status = ST_MALFORMED;
			end else begin
				t1 = stamp_ms(sent_seen);
				t2 = stamp_ms(recv_seen);
				t3 = stamp_ms(xmit_seen);
				t4 = stamp_ms(arrv_seen);
				// signed division rounds toward zero
				off_ms = ((t2 - t1) + (t3 - t4)) / 2;
				del_ms = (t4 - t1) - (t3 - t2);
				if (del_ms < 0)
					del_ms = 0;
				if (del_ms > DelayCap)
					del_ms = DelayCap;
				r.clk_offset = off_ms[43:0];
				r.rtt_delay  = del_ms[42:0];
			end
		end
		status_hits[r.status]++;
		expected_reports.push_back(r);
	endtask

	// result side: check every accepted result against the oldest prediction
	always @(posedge clk) begin : res_check
		rpc_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_checked++;
			if (expected_reports.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(res.status), '0);
			end else begin
				want = expected_reports.pop_front();
				if (res.status !== want.status)
					report_mismatch("status", 64'(res.status), 64'(want.status));
				if (res.clk_offset !== want.clk_offset)
					report_mismatch("clk_offset", 64'(res.clk_offset),
						64'(want.clk_offset));
				if (res.rtt_delay !== want.rtt_delay)
					report_mismatch("rtt_delay", 64'(res.rtt_delay), 64'(want.rtt_delay));
				if (res.stratum !== want.stratum)
					report_mismatch("stratum", 64'(res.stratum), 64'(want.stratum));
				if (res.ref_id !== want.ref_id)
					report_mismatch("ref_id", 64'(res.ref_id), 64'(want.ref_id));
			end
		end
	end

	// result stall: long hold-offs on request, short random bursts otherwise
	initial begin : res_side
		int burst;
		burst = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_stall = 1'b1;
				hold_cycles--;
			end else if (burst > 0) begin
				res_stall = 1'b1;
				burst--;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				res_stall = 1'b1;
				burst = $urandom_range(0, 6);
			end else begin
				res_stall = 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < IdleLimit) begin
			@(posedge clk);
			if ((msg_valid && !msg_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", IdleLimit);
		$display("tb_ntp_reply_check_offset_delay_core failed");
		$finish;
	end

	// offer one byte at the falling edge and hold it until taken
	task automatic send_byte(input rpc_in_t item);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 7);
			msg_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_valid = 1'b1;
		msg = item;
		do begin
			@(posedge clk);
		end while (msg_stall);
		track_reply_byte(item);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [63:0] sent, input logic [63:0] arrived);
		rpc_in_t item;
		foreach (frame[i]) begin
			item.msg_byte     = frame[i];
			item.last_byte    = (i == frame.size() - 1);
			item.sent_time    = (i == 0) ? sent : {$urandom, $urandom};
			item.arrived_time = (i == 0) ? arrived : {$urandom, $urandom};
			send_byte(item);
		end
		replies_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		msg_valid = 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] ntp_header(input logic [1:0] leap, input logic [2:0] ver,
			input logic [2:0] mode);
		return {leap, ver, mode};
	endfunction

	task automatic build_reply(input logic [7:0] hdr, input logic [7:0] strat,
			input logic [31:0] rid, input logic [63:0] orig, input logic [63:0] recv,
			input logic [63:0] xmit);
		frame.delete();
		repeat (POS_END) frame.push_back(8'($urandom));
		frame[POS_HEADER]  = hdr;
		frame[POS_STRATUM] = strat;
		for (int i = 0; i < 4; i++)
			frame[POS_REF_LO + i] = rid[31 - 8 * i -: 8];
		for (int i = 0; i < 8; i++) begin
			frame[POS_ORIG_LO + i] = orig[63 - 8 * i -: 8];
			frame[POS_RECV_LO + i] = recv[63 - 8 * i -: 8];
			frame[POS_XMIT_LO + i] = xmit[63 - 8 * i -: 8];
		end
	endtask

	task automatic resize_frame(input int len);
		while (frame.size() > len)
			void'(frame.pop_back());
		while (frame.size() < len)
			frame.push_back(8'($urandom));
	endtask

	task automatic send_reply(input logic [7:0] hdr, input logic [7:0] strat,
			input logic [63:0] sent, input logic [63:0] orig, input logic [63:0] recv,
			input logic [63:0] xmit, input logic [63:0] arrived);
		build_reply(hdr, strat, $urandom, orig, recv, xmit);
		send_frame(sent, arrived);
	endtask

	task automatic random_reply();
		int          kind;
		logic [1:0]  leap;
		logic [2:0]  ver;
		logic [2:0]  mode;
		logic [7:0]  strat;
		logic [63:0] sent, orig, recv, xmit, arrived, swing;
		kind = $urandom_range(0, 99);
		sent = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) begin
			recv    = {$urandom, $urandom};
			xmit    = {$urandom, $urandom};
			arrived = {$urandom, $urandom};
		end else begin
			// plausible exchange: server clock off by a swing, short path both ways
			swing = {32'd0, $urandom} << $urandom_range(0, 8);
			recv = $urandom_range(0, 1) ? sent + swing : sent - swing;
			xmit = recv + {44'd0, 20'($urandom)};
			arrived = xmit - recv + sent + {40'd0, 24'($urandom)} - {42'd0, 22'($urandom)};
		end
		leap = ($urandom_range(0, 9) == 0) ? LEAP_ALARM : 2'($urandom_range(0, 2));
		ver  = ($urandom_range(0, 9) == 0) ? 3'($urandom) :
			($urandom_range(0, 1) ? VERSION_LO : VERSION_HI);
		mode = ($urandom_range(0, 9) == 0) ? 3'($urandom) : MODE_SERVER;
		case ($urandom_range(0, 19))
			0:       strat = 8'd0;
			1, 2:    strat = 8'($urandom_range(16, 255));
			default: strat = 8'($urandom_range(1, 15));
		endcase
		orig = ($urandom_range(0, 12) == 0) ? {$urandom, $urandom} : sent;
		if ($urandom_range(0, 19) == 0)
			xmit = '0;
		build_reply(ntp_header(leap, ver, mode), strat, $urandom, orig, recv, xmit);
		if (kind >= 92) begin
			foreach (frame[i])
				frame[i] = 8'($urandom);
		end else if (kind >= 82) begin
			resize_frame($urandom_range(49, 80));
		end else if (kind >= 70) begin
			resize_frame($urandom_range(1, 47));
		end
		send_frame(sent, arrived);
	endtask

	task automatic test_server_replies();
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd1,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_ADD, VERSION_LO, MODE_SERVER), 8'd15,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd2,
			StampArrv, StampArrv, StampSent, StampRecv, StampXmit);
	endtask

	task automatic test_header_checks();
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_CLIENT), 8'd2,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_LO, MODE_BCAST), 8'd2,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_OLD, MODE_SERVER), 8'd2,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_NEXT, MODE_SERVER), 8'd2,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		// mode is checked ahead of version
		send_reply(ntp_header(LEAP_NONE, VERSION_OLD, MODE_CLIENT), 8'd2,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
	endtask

	task automatic test_server_state();
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd0,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), STRATUM_UNSYNC,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_LO, MODE_SERVER), 8'd255,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_ALARM, VERSION_HI, MODE_SERVER), 8'd2,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
		// kiss wins over an alarm leap
		send_reply(ntp_header(LEAP_ALARM, VERSION_HI, MODE_SERVER), 8'd0,
			StampSent, StampSent, StampRecv, StampXmit, StampArrv);
	endtask

	task automatic test_stamp_checks();
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd3,
			StampSent, StampRecv, StampRecv, StampXmit, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd3,
			StampSent, StampSent, StampRecv, '0, StampArrv);
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd3,
			StampSent, StampRecv, StampRecv, '0, StampArrv);
	endtask

	task automatic test_reply_lengths();
		int lens[7];
		lens = '{1, 2, 47, 49, 63, 64, 80};
		foreach (lens[i]) begin
			build_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd2, $urandom,
				StampSent, StampRecv, StampXmit);
			resize_frame(lens[i]);
			send_frame(StampSent, StampArrv);
		end
	endtask

	task automatic test_stamp_extremes();
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd1,
			'0, '0, '0, 64'd1, '0);
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd1,
			StampOnes, StampOnes, StampOnes, StampOnes, StampOnes);
		// twice the full range, the largest delay the stamps can give
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd1,
			'0, '0, StampOnes, 64'd1, StampOnes);
		// odd negative sum and a negative delay: offset -999, delay 0
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd1,
			{32'd10, 32'd0}, {32'd10, 32'd0}, {32'd9, 32'd0}, {32'd9, 32'h0041_8938},
			{32'd10, 32'd0});
		send_reply(ntp_header(LEAP_NONE, VERSION_HI, MODE_SERVER), 8'd1,
			StampOnes, StampOnes, '0, StampOnes, '0);
	endtask

	// stall results for a long stretch while single-byte replies keep coming
	task automatic test_output_backpressure();
		wait_drain();
		hold_cycles = 90;
		repeat (40) begin
			frame.delete();
			frame.push_back(8'($urandom));
			send_frame({$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	task automatic test_sender_pause();
		repeat (2) random_reply();
		wait_drain();
		repeat (2) random_reply();
	endtask

	task automatic test_random_replies(input int byte_goal, input int reply_goal);
		int first_byte;
		int first_reply;
		first_byte  = bytes_sent;
		first_reply = replies_sent;
		while (bytes_sent - first_byte < byte_goal || replies_sent - first_reply < reply_goal)
			random_reply();
	endtask

	initial begin
		arst_n          = 1'b0;
		msg_valid       = 1'b0;
		msg             = '0;
		idle_en         = 1'b0;
		hold_cycles     = 0;
		errors          = 0;
		bytes_sent      = 0;
		replies_sent    = 0;
		results_checked = 0;
		status_hits     = '{default: 0};
		reply_pos       = '0;
		hdr_seen        = '0;
		strat_seen      = '0;
		refid_seen      = '0;
		orig_seen       = '0;
		recv_seen       = '0;
		xmit_seen       = '0;
		sent_seen       = '0;
		arrv_seen       = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_server_replies();
		test_header_checks();
		test_server_state();
		test_stamp_checks();
		test_reply_lengths();
		test_stamp_extremes();
		idle_en = 1'b1;
		test_output_backpressure();
		test_sender_pause();
		test_random_replies(RandBytes, MinReplies);
		idle_en = 1'b0;
		test_random_replies(60, 1);

		wait_drain();
		repeat (DrainWait) @(posedge clk);
		if (expected_reports.size() != 0)
			report_mismatch("results never delivered", '0, 64'(expected_reports.size()));
		$display("covered %0d replies, %0d bytes: header, stamp, length and stall tests,",
			replies_sent, bytes_sent);
		$display("random traffic; results %0d = %0d/%0d/%0d/%0d/%0d by status",
			results_checked, status_hits[ST_OK], status_hits[ST_MALFORMED],
			status_hits[ST_MISMATCH], status_hits[ST_KISS], status_hits[ST_UNSYNCED]);
		if (errors == 0)
			$display("tb_ntp_reply_check_offset_delay_core passed");
		else
			$display("tb_ntp_reply_check_offset_delay_core failed");
		$finish;
	end

endmodule
